FILE: src/ast_pkg.sv
// Shared types and constants for the associative slot table.
`default_nettype none
package ast_pkg;

  localparam int KEY_W  = 16;
  localparam int CMD_W  = 2;
  localparam int SLOT_W = 6;
  localparam int CNT_OW = 6;

  localparam logic [KEY_W-1:0] EMPTY_KEY = 16'hFFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP  = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_COUNT   = 2'd3
  } ast_cmd_t;

  // Search token that walks the cell row.
  typedef struct packed {
    logic             vld;
    ast_cmd_t         cmd;
    logic [KEY_W-1:0] key;
    logic             hit;   // a cell further up holds the key
    logic             free;  // a cell further up is empty
  } ast_tok_t;

  // Write broadcast from the resolve logic to every cell.
  typedef struct packed {
    logic             we;
    logic             clr;
    logic [KEY_W-1:0] data;
  } ast_wr_t;

endpackage
`default_nettype wire

FILE: src/ast_cell.sv
// One table entry with its slice of the match, free and count search.
`default_nettype none
module ast_cell import ast_pkg::*; #(
  parameter int SLOTS    = 32,
  parameter int CELL_IDX = 0
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire ast_tok_t                               tok_i,
  input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] hit_idx_i,
  input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] free_idx_i,
  input  wire logic [$clog2(SLOTS+1)-1:0]             cnt_i,
  output ast_tok_t                                    tok_o,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] hit_idx_o,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] free_idx_o,
  output logic [$clog2(SLOTS+1)-1:0]                  cnt_o,
  input  wire ast_wr_t                                wr_i,
  input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] widx_i
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS+1);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [KEY_W-1:0] key_r;
  ast_tok_t         tok_r, tok_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt, free_idx_r, free_idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             occ, match;

  assign occ   = (key_r != EMPTY_KEY);
  // The empty marker never matches, so an empty entry cannot look like a hit.
  assign match = (tok_i.key != EMPTY_KEY) && (key_r == tok_i.key);

  always_comb begin
    tok_nxt      = tok_i;
    hit_idx_nxt  = hit_idx_i;
    free_idx_nxt = free_idx_i;
    cnt_nxt      = cnt_i + CNT_W'(occ);
    if (!tok_i.hit && match) begin
      tok_nxt.hit = 1'b1;
      hit_idx_nxt = MY_IDX;
    end
    if (!tok_i.free && !occ) begin
      tok_nxt.free = 1'b1;
      free_idx_nxt = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= EMPTY_KEY;
    end else if (wr_i.clr) begin
      key_r <= EMPTY_KEY;
    end else if (wr_i.we && (widx_i == MY_IDX)) begin
      key_r <= wr_i.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.cmd  <= tok_nxt.cmd;
    tok_r.key  <= tok_nxt.key;
    tok_r.hit  <= tok_nxt.hit;
    tok_r.free <= tok_nxt.free;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    cnt_r      <= cnt_nxt;
  end

  assign tok_o      = tok_r;
  assign hit_idx_o  = hit_idx_r;
  assign free_idx_o = free_idx_r;
  assign cnt_o      = cnt_r;

endmodule
`default_nettype wire

FILE: src/associative_slot_table_top.sv
// Top level of the associative slot table: cell row, resolve logic and result register.
//
//   channel | ports                          | payload
//   --------+--------------------------------+-------------------------------------------
//   input   | in_tvalid in_tready in_tdata   | tdata: key[15:0]; tuser: cmd[1:0]
//           | in_tuser                       |
//   result  | out_tvalid out_tready out_tdata| tdata: slot[5:0] hit[6] full_res[7]
//           |                                |        occupied_count[13:8], zero pad
//
// A request walks the row of SLOTS cells one cell per cycle and then waits in the tail
// register; its result moves to the output register, and the next request is taken once
// busy clears after that move; one request is in flight at a time.
// Reset empties every entry at once; the block takes a request the first cycle after reset.
// A stalled result waits in the output register while the next request is already walking.
// A finished search waits at the end of the row until the output register is free.
`default_nettype none
module associative_slot_table_top import ast_pkg::*; #(
  parameter int SLOTS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // key[15:0]
  input  wire logic [1:0]  in_tuser,   // cmd[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // slot[5:0], hit, full_res, occupied_count[13:8]
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS+1);
  localparam int SUM_W = IDX_W + 1;

  ast_tok_t         tok_c  [SLOTS+1];
  logic [IDX_W-1:0] hidx_c [SLOTS+1];
  logic [IDX_W-1:0] fidx_c [SLOTS+1];
  logic [CNT_W-1:0] cnt_c  [SLOTS+1];
  logic [SLOTS-1:0] row_vld;

  ast_wr_t          wr;
  logic [IDX_W-1:0] widx;

  logic             busy_r;
  logic             accept, fin;

  ast_tok_t         tail_r;
  logic             tail_vld_r;
  logic [IDX_W-1:0] tail_hidx_r, tail_fidx_r;
  logic [CNT_W-1:0] tail_cnt_r;

  logic             out_vld_r;
  logic [15:0]      out_data_r, out_data_nxt;

  logic [SUM_W-1:0] slot_wide;
  logic [CNT_W-1:0] cnt_new;
  logic             res_hit, res_full;

  assign in_tready = !busy_r;
  assign accept    = in_tvalid && in_tready;
  assign fin       = tail_vld_r && (!out_vld_r || out_tready);

  always_comb begin
    tok_c[0].vld  = accept;
    tok_c[0].cmd  = ast_cmd_t'(in_tuser);
    tok_c[0].key  = in_tdata;
    tok_c[0].hit  = 1'b0;
    tok_c[0].free = 1'b0;
    hidx_c[0]     = '0;
    fidx_c[0]     = '0;
    cnt_c[0]      = '0;
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    ast_cell #(
      .SLOTS    (SLOTS),
      .CELL_IDX (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .tok_i      (tok_c[g]),
      .hit_idx_i  (hidx_c[g]),
      .free_idx_i (fidx_c[g]),
      .cnt_i      (cnt_c[g]),
      .tok_o      (tok_c[g+1]),
      .hit_idx_o  (hidx_c[g+1]),
      .free_idx_o (fidx_c[g+1]),
      .cnt_o      (cnt_c[g+1]),
      .wr_i       (wr),
      .widx_i     (widx)
    );
    assign row_vld[g] = tok_c[g+1].vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      tail_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
      end else if (fin) begin
        busy_r <= 1'b0;
      end
      if (tok_c[SLOTS].vld) begin
        tail_vld_r <= 1'b1;
      end else if (fin) begin
        tail_vld_r <= 1'b0;
      end
      if (fin) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_c[SLOTS].vld) begin
      tail_r      <= tok_c[SLOTS];
      tail_hidx_r <= hidx_c[SLOTS];
      tail_fidx_r <= fidx_c[SLOTS];
      tail_cnt_r  <= cnt_c[SLOTS];
    end
    if (fin) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Turn the search outcome into the table update and the result.
  always_comb begin
    wr.we     = 1'b0;
    wr.clr    = 1'b0;
    wr.data   = tail_r.key;
    widx      = tail_hidx_r;
    slot_wide = '0;
    res_hit   = 1'b0;
    res_full  = 1'b0;
    cnt_new   = tail_cnt_r;
    case (tail_r.cmd)
      CMD_LOOKUP: begin
        if (tail_r.key != EMPTY_KEY) begin
          if (tail_r.hit) begin
            slot_wide = SUM_W'(tail_hidx_r) + SUM_W'(1);
            res_hit   = 1'b1;
          end else if (tail_r.free) begin
            wr.we     = fin;
            widx      = tail_fidx_r;
            slot_wide = SUM_W'(tail_fidx_r) + SUM_W'(1);
            cnt_new   = tail_cnt_r + CNT_W'(1);
          end else begin
            res_full = 1'b1;
          end
        end
      end
      CMD_RELEASE: begin
        if (tail_r.hit) begin
          wr.we     = fin;
          wr.data   = EMPTY_KEY;
          slot_wide = SUM_W'(tail_hidx_r) + SUM_W'(1);
          res_hit   = 1'b1;
          cnt_new   = tail_cnt_r - CNT_W'(1);
        end
      end
      CMD_CLEAR: begin
        wr.clr  = fin;
        cnt_new = '0;
      end
      default: begin
      end
    endcase
    out_data_nxt = {2'b00, CNT_OW'(cnt_new), res_full, res_hit, SLOT_W'(slot_wide)};
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(row_vld) + $countones(tail_vld_r)) <= 1)
    else $error("more than one request in the cell row");

  a_enter_row: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (row_vld[0] && busy_r))
    else $error("accepted request did not enter the first cell");

  a_fin_frees: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> (!busy_r && out_vld_r && !tail_vld_r))
    else $error("finished request did not free the block");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    tail_vld_r |-> (tail_cnt_r <= CNT_W'(SLOTS)))
    else $error("occupied count beyond table size");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !fin) |=> !$past(accept))
    else $error("request accepted while busy");

endmodule
`default_nettype wire
